[hdl/hsv_color_adjust_unit_assert.svh]
// Assertion macros for the HSV color adjust unit.
`ifndef HSV_COLOR_ADJUST_UNIT_ASSERT_SVH
`define HSV_COLOR_ADJUST_UNIT_ASSERT_SVH

// Check that cond implies prop in the same cycle.
`define HCA_ASSERT_IMPLY(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error("hca assertion failed");

// Check that cond implies prop in the next cycle.
`define HCA_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error("hca assertion failed");

`endif

[hdl/hca_pkg.sv]
// Shared constants, types and helpers of the HSV color adjust unit.
package hca_pkg;

    localparam int ONE_Q16    = 65536;
    localparam int HALF_Q16   = 32768;
    localparam int HUE_FULL   = 5760;
    localparam int HUE_SECTOR = 960;
    localparam int GAIN_MAX   = 256;

    localparam int PIX_W  = 32;
    localparam int CH_W   = 8;
    localparam int Q16_W  = 17;
    localparam int HUE_W  = 13;
    localparam int FRAC_W = 10;
    localparam int SEC_W  = 3;
    localparam int GAIN_W = 10;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_ADDR_W-1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CONTRAST   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SATURATION = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HUE        = 2'd3;

    // Pipelined restoring divider: quotient bits retired per stage.
    localparam int DIV_W      = 24;
    localparam int DVS_W      = 8;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DIV_W / DIV_STEP;

    // Items riding alongside the divider.
    typedef struct packed {
        logic [PIX_W-1:0] argb;
        logic [Q16_W-1:0] v0;
        logic [HUE_W-1:0] hbase;
        logic             gray;
        logic             black;
    } hca_side_t;

    // Adjusted color handed to the back end.
    typedef struct packed {
        logic              valid;
        logic [PIX_W-1:0]  argb;
        logic [Q16_W-1:0]  c;
        logic [Q16_W-1:0]  v;
        logic [SEC_W-1:0]  sector;
        logic [FRAC_W-1:0] frac;
    } hca_hsv_t;

    function automatic logic signed [GAIN_W-1:0] gain_clamp(input logic [GAIN_W-1:0] raw);
        logic signed [GAIN_W-1:0] g;
        g = signed'(raw);
        if (g < -GAIN_MAX) begin
            g = GAIN_W'(-GAIN_MAX);
        end else if (g > GAIN_MAX) begin
            g = GAIN_W'(GAIN_MAX);
        end
        return g;
    endfunction

endpackage

[hdl/hsv_color_adjust_unit.sv]
// Throughput: one item per clock while no result waits on m_ready; two 6-stage pipelined dividers set the depth.
// The whole pipeline advances together and holds while a result waits.
// Reset (aresetn low, synchronous) clears all valid bits and zeroes the settings.
module hsv_color_adjust_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [hca_pkg::PIX_W-1:0]      s_argb_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [hca_pkg::PIX_W-1:0]      m_argb_out,
    input  logic                           cfg_wr_en,
    input  logic [hca_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [hca_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import hca_pkg::*;
    `include "hsv_color_adjust_unit_assert.svh"

    logic [GAIN_W-1:0] brightness_reg, contrast_reg, saturation_reg;
    logic [HUE_W-1:0]  hue_reg;
    logic              en, bypass;

    logic              div_valid, side_valid, s_div_valid, h_div_valid;
    logic [DIV_W-1:0]  s_dividend, h_dividend, q_s, q_h;
    logic [DVS_W-1:0]  s_divisor, h_divisor;
    hca_side_t         side;
    hca_hsv_t          hsv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= '0;
            contrast_reg   <= '0;
            saturation_reg <= '0;
            hue_reg        <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_BRIGHTNESS: brightness_reg <= cfg_wdata[GAIN_W-1:0];
                REG_CONTRAST:   contrast_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_SATURATION: saturation_reg <= cfg_wdata[GAIN_W-1:0];
                REG_HUE:        hue_reg        <= cfg_wdata[HUE_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance whenever the output register is empty or being drained.
    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign bypass  = (brightness_reg == '0) && (contrast_reg == '0) &&
                     (saturation_reg == '0) && (hue_reg == '0);

    hca_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .s_valid    (s_valid),
        .s_argb_in  (s_argb_in),
        .div_valid  (div_valid),
        .s_dividend (s_dividend),
        .s_divisor  (s_divisor),
        .h_dividend (h_dividend),
        .h_divisor  (h_divisor),
        .side_out   (side),
        .side_valid (side_valid)
    );

    hca_div u_div_sat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_valid),
        .dividend  (s_dividend),
        .divisor   (s_divisor),
        .out_valid (s_div_valid),
        .quotient  (q_s)
    );

    hca_div u_div_hue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_valid),
        .dividend  (h_dividend),
        .divisor   (h_divisor),
        .out_valid (h_div_valid),
        .quotient  (q_h)
    );

    hca_adjust u_adjust (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (side_valid),
        .side_in    (side),
        .q_s        (q_s),
        .q_h        (q_h),
        .brightness (brightness_reg),
        .contrast   (contrast_reg),
        .saturation (saturation_reg),
        .hue        (hue_reg),
        .hsv_out    (hsv)
    );

    hca_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .bypass    (bypass),
        .hsv_in    (hsv),
        .out_valid (m_valid),
        .out_argb  (m_argb_out)
    );

    `HCA_ASSERT_IMPLY(a_div_aligned, aclk, aresetn, 1'b1,
        (s_div_valid == side_valid) && (h_div_valid == side_valid))
    `HCA_ASSERT_IMPLY(a_chroma_le_value, aclk, aresetn, hsv.valid, hsv.c <= hsv.v)
    `HCA_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_argb_out))

endmodule

[hdl/hca_div.sv]
// Pipelined restoring divider, a few quotient bits per stage.
module hca_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [hca_pkg::DIV_W-1:0] dividend,
    input  logic [hca_pkg::DVS_W-1:0] divisor,
    output logic                      out_valid,
    output logic [hca_pkg::DIV_W-1:0] quotient
);
    import hca_pkg::*;

    logic [DVS_W-1:0] rem_reg [DIV_STAGES];
    logic [DIV_W-1:0] num_reg [DIV_STAGES];
    logic [DIV_W-1:0] quo_reg [DIV_STAGES];
    logic [DVS_W-1:0] dvs_reg [DIV_STAGES];
    logic             vld_reg [DIV_STAGES];

    logic [DVS_W-1:0] rem_next [DIV_STAGES];
    logic [DIV_W-1:0] num_next [DIV_STAGES];
    logic [DIV_W-1:0] quo_next [DIV_STAGES];
    logic [DVS_W-1:0] dvs_next [DIV_STAGES];

    always_comb begin
        logic [DVS_W:0]   trial;
        logic [DVS_W-1:0] rem;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] quo;
        logic [DVS_W-1:0] dvs;
        for (int st = 0; st < DIV_STAGES; st++) begin
            if (st == 0) begin
                rem = '0;
                num = dividend;
                quo = '0;
                dvs = divisor;
            end else begin
                rem = rem_reg[st-1];
                num = num_reg[st-1];
                quo = quo_reg[st-1];
                dvs = dvs_reg[st-1];
            end
            for (int b = 0; b < DIV_STEP; b++) begin
                trial = {rem, num[DIV_W-1]};
                num   = {num[DIV_W-2:0], 1'b0};
                if (trial >= {1'b0, dvs}) begin
                    rem = DVS_W'(trial - {1'b0, dvs});
                    quo = {quo[DIV_W-2:0], 1'b1};
                end else begin
                    rem = trial[DVS_W-1:0];
                    quo = {quo[DIV_W-2:0], 1'b0};
                end
            end
            rem_next[st] = rem;
            num_next[st] = num;
            quo_next[st] = quo;
            dvs_next[st] = dvs;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int st = 0; st < DIV_STAGES; st++) begin
                vld_reg[st] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int st = 1; st < DIV_STAGES; st++) begin
                vld_reg[st] <= vld_reg[st-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int st = 0; st < DIV_STAGES; st++) begin
                rem_reg[st] <= rem_next[st];
                num_reg[st] <= num_next[st];
                quo_reg[st] <= quo_next[st];
                dvs_reg[st] <= dvs_next[st];
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign quotient  = quo_reg[DIV_STAGES-1];

endmodule

[hdl/hca_front.sv]
// Front end: max/min, hue numerator, divider operands and side delay line.
module hca_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      s_valid,
    input  logic [hca_pkg::PIX_W-1:0] s_argb_in,
    output logic                      div_valid,
    output logic [hca_pkg::DIV_W-1:0] s_dividend,
    output logic [hca_pkg::DVS_W-1:0] s_divisor,
    output logic [hca_pkg::DIV_W-1:0] h_dividend,
    output logic [hca_pkg::DVS_W-1:0] h_divisor,
    output hca_pkg::hca_side_t        side_out,
    output logic                      side_valid
);
    import hca_pkg::*;

    localparam int HNUM_W = 19;

    logic [CH_W-1:0]   r, g, b, cmax, cmin, delta;
    logic [CH_W:0]     num;
    logic [HNUM_W-1:0] hnum;
    logic [HUE_W-1:0]  hbase;
    hca_side_t         side_next;

    logic [DIV_W-1:0] s_dividend_reg, h_dividend_reg;
    logic [DVS_W-1:0] s_divisor_reg, h_divisor_reg;
    hca_side_t        side_reg [DIV_STAGES+1];
    logic             vld_reg  [DIV_STAGES+1];

    always_comb begin
        r = s_argb_in[23:16];
        g = s_argb_in[15:8];
        b = s_argb_in[7:0];
        cmax = r;
        if (g > cmax) cmax = g;
        if (b > cmax) cmax = b;
        cmin = r;
        if (g < cmin) cmin = g;
        if (b < cmin) cmin = b;
        delta = cmax - cmin;
        // Sector numerator and base follow the channel that holds the max.
        if (cmax == r) begin
            num   = {1'b0, g} + {1'b0, delta} - {1'b0, b};
            hbase = HUE_W'(5 * HUE_SECTOR);
        end else if (cmax == g) begin
            num   = {1'b0, b} + {1'b0, delta} - {1'b0, r};
            hbase = HUE_W'(HUE_SECTOR);
        end else begin
            num   = {1'b0, r} + {1'b0, delta} - {1'b0, g};
            hbase = HUE_W'(3 * HUE_SECTOR);
        end
        hnum = (HNUM_W'(num) << 10) - (HNUM_W'(num) << 6);
        side_next.argb  = s_argb_in;
        // cmax*65536/255 = cmax*257, plus one at full scale.
        side_next.v0    = (Q16_W'(cmax) << 8) + Q16_W'(cmax) + Q16_W'(cmax == 8'hFF);
        side_next.hbase = hbase;
        side_next.gray  = (delta == '0);
        side_next.black = (cmax == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= DIV_STAGES; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i <= DIV_STAGES; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_dividend_reg <= {delta, 16'h0000};
            s_divisor_reg  <= cmax;
            h_dividend_reg <= DIV_W'(hnum);
            h_divisor_reg  <= delta;
            side_reg[0]    <= side_next;
            for (int i = 1; i <= DIV_STAGES; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign div_valid  = vld_reg[0];
    assign s_dividend = s_dividend_reg;
    assign s_divisor  = s_divisor_reg;
    assign h_dividend = h_dividend_reg;
    assign h_divisor  = h_divisor_reg;
    assign side_out   = side_reg[DIV_STAGES];
    assign side_valid = vld_reg[DIV_STAGES];

endmodule

[hdl/hca_adjust.sv]
// Adjust stages: brightness, contrast, saturation, hue rotation, chroma.
module hca_adjust (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  hca_pkg::hca_side_t         side_in,
    input  logic [hca_pkg::DIV_W-1:0]  q_s,
    input  logic [hca_pkg::DIV_W-1:0]  q_h,
    input  logic [hca_pkg::GAIN_W-1:0] brightness,
    input  logic [hca_pkg::GAIN_W-1:0] contrast,
    input  logic [hca_pkg::GAIN_W-1:0] saturation,
    input  logic [hca_pkg::HUE_W-1:0]  hue,
    output hca_pkg::hca_hsv_t          hsv_out
);
    import hca_pkg::*;

    logic signed [GAIN_W-1:0] bg, cg, sg;

    // First stage: hue assembly, saturation, brightness.
    logic [HUE_W-1:0]  h8_next, h8_reg;
    logic [Q16_W-1:0]  s8_next, s8_reg, v8_next, v8_reg;
    logic signed [18:0] vb;
    logic [PIX_W-1:0]  argb8_reg;
    logic              vld8_reg;

    // Second stage: contrast, saturation gain, hue offset.
    logic signed [17:0] vd;
    logic signed [10:0] kc, ks;
    logic signed [28:0] pc;
    logic signed [20:0] vr;
    logic [26:0]        ps;
    logic [18:0]        ss;
    logic [HUE_W-1:0]   hoff;
    logic [HUE_W:0]     hs;
    logic [HUE_W-1:0]  h9_next, h9_reg;
    logic [Q16_W-1:0]  s9_next, s9_reg, v9_next, v9_reg;
    logic [PIX_W-1:0]  argb9_reg;
    logic              vld9_reg;

    // Third stage: chroma and sector split.
    logic [2*Q16_W-1:0] pvs;
    logic [SEC_W-1:0]   sec;
    logic [HUE_W-1:0]   rest;
    hca_hsv_t           hsv_next, hsv_reg;

    always_comb begin
        bg = gain_clamp(brightness);
        cg = gain_clamp(contrast);
        sg = gain_clamp(saturation);

        h8_next = side_in.gray ? '0 : HUE_W'(q_h[10:0]) + side_in.hbase;
        if (h8_next >= HUE_W'(HUE_FULL)) h8_next = h8_next - HUE_W'(HUE_FULL);
        s8_next = side_in.black ? '0 : Q16_W'(q_s);
        vb = $signed({2'b00, side_in.v0}) + ($signed({{9{bg[GAIN_W-1]}}, bg}) <<< 8);
        if (vb < 0) begin
            v8_next = '0;
        end else if (vb > 19'sd65536) begin
            v8_next = Q16_W'(ONE_Q16);
        end else begin
            v8_next = vb[Q16_W-1:0];
        end

        vd = $signed({1'b0, v8_reg}) - 18'sd32768;
        kc = 11'sd256 + $signed({cg[GAIN_W-1], cg});
        pc = vd * kc;
        vr = 21'(pc >>> 8) + 21'sd32768;
        if (vr < 0) begin
            v9_next = '0;
        end else if (vr > 21'sd65536) begin
            v9_next = Q16_W'(ONE_Q16);
        end else begin
            v9_next = vr[Q16_W-1:0];
        end
        ks = 11'sd256 + $signed({sg[GAIN_W-1], sg});
        ps = s8_reg * ks[9:0];
        ss = ps[26:8];
        s9_next = (ss > 19'd65536) ? Q16_W'(ONE_Q16) : ss[Q16_W-1:0];
        hoff = (hue >= HUE_W'(HUE_FULL)) ? hue - HUE_W'(HUE_FULL) : hue;
        hs = {1'b0, h8_reg} + {1'b0, hoff};
        if (hs >= (HUE_W+1)'(HUE_FULL)) hs = hs - (HUE_W+1)'(HUE_FULL);
        h9_next = hs[HUE_W-1:0];

        pvs = v9_reg * s9_reg;
        sec  = '0;
        rest = h9_reg;
        for (int k = 1; k < 6; k++) begin
            if (rest >= HUE_W'(HUE_SECTOR)) begin
                rest = rest - HUE_W'(HUE_SECTOR);
                sec  = SEC_W'(k);
            end
        end
        hsv_next.valid  = vld9_reg;
        hsv_next.argb   = argb9_reg;
        hsv_next.c      = pvs[2*Q16_W-2:16];
        hsv_next.v      = v9_reg;
        hsv_next.sector = sec;
        hsv_next.frac   = rest[FRAC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld8_reg      <= 1'b0;
            vld9_reg      <= 1'b0;
            hsv_reg.valid <= 1'b0;
        end else if (en) begin
            vld8_reg  <= in_valid;
            vld9_reg  <= vld8_reg;
            h8_reg    <= h8_next;
            s8_reg    <= s8_next;
            v8_reg    <= v8_next;
            argb8_reg <= side_in.argb;
            h9_reg    <= h9_next;
            s9_reg    <= s9_next;
            v9_reg    <= v9_next;
            argb9_reg <= argb8_reg;
            hsv_reg   <= hsv_next;
        end
    end

    assign hsv_out = hsv_reg;

endmodule

[hdl/hca_back.sv]
// Back end: HSV to RGB, channel scaling and output register.
module hca_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      bypass,
    input  hca_pkg::hca_hsv_t         hsv_in,
    output logic                      out_valid,
    output logic [hca_pkg::PIX_W-1:0] out_argb
);
    import hca_pkg::*;

    localparam logic [15:0] RECIP15 = 16'd34953;

    logic [FRAC_W-1:0] fsel;
    logic [26:0]       pcf;

    logic [19:0]       y11_reg, y12_reg;
    logic [Q16_W-1:0]  c11_reg, v11_reg, c12_reg, v12_reg;
    logic [SEC_W-1:0]  sec11_reg, sec12_reg;
    logic [PIX_W-1:0]  argb11_reg, argb12_reg, argb13_reg;
    logic              vld11_reg, vld12_reg, vld13_reg, vld14_reg;

    logic [35:0]       pq;
    logic [Q16_W-1:0]  q12_reg;

    logic [21:0]       q15;
    logic [Q16_W-1:0]  x, m, rc, gc, bc;
    logic [Q16_W-1:0]  tr_reg, tg_reg, tb_reg;

    logic [24:0]       sr, sgr, sb;
    logic [PIX_W-1:0]  argb14_reg;

    always_comb begin
        fsel = hsv_in.sector[0] ? FRAC_W'(HUE_SECTOR) - hsv_in.frac : hsv_in.frac;
        pcf  = hsv_in.c * fsel;

        // Divide by 15 through a reciprocal; the estimate is at most one high.
        pq = y11_reg * RECIP15;

        q15 = (22'(q12_reg) << 4) - 22'(q12_reg);
        x   = (q15 > 22'(y12_reg)) ? q12_reg - 1'b1 : q12_reg;
        m   = v12_reg - c12_reg;
        case (sec12_reg)
            3'd0: begin rc = c12_reg; gc = x;       bc = '0;      end
            3'd1: begin rc = x;       gc = c12_reg; bc = '0;      end
            3'd2: begin rc = '0;      gc = c12_reg; bc = x;       end
            3'd3: begin rc = '0;      gc = x;       bc = c12_reg; end
            3'd4: begin rc = x;       gc = '0;      bc = c12_reg; end
            default: begin rc = c12_reg; gc = '0;   bc = x;       end
        endcase

        sr  = (25'(tr_reg) << 8) - 25'(tr_reg);
        sgr = (25'(tg_reg) << 8) - 25'(tg_reg);
        sb  = (25'(tb_reg) << 8) - 25'(tb_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld11_reg <= 1'b0;
            vld12_reg <= 1'b0;
            vld13_reg <= 1'b0;
            vld14_reg <= 1'b0;
        end else if (en) begin
            vld11_reg <= hsv_in.valid;
            vld12_reg <= vld11_reg;
            vld13_reg <= vld12_reg;
            vld14_reg <= vld13_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y11_reg    <= pcf[25:6];
            c11_reg    <= hsv_in.c;
            v11_reg    <= hsv_in.v;
            sec11_reg  <= hsv_in.sector;
            argb11_reg <= hsv_in.argb;

            q12_reg    <= pq[35:19];
            y12_reg    <= y11_reg;
            c12_reg    <= c11_reg;
            v12_reg    <= v11_reg;
            sec12_reg  <= sec11_reg;
            argb12_reg <= argb11_reg;

            tr_reg     <= rc + m;
            tg_reg     <= gc + m;
            tb_reg     <= bc + m;
            argb13_reg <= argb12_reg;

            // Hold the original pixel when every setting is zero.
            argb14_reg <= bypass ? argb13_reg
                                 : {argb13_reg[31:24], sr[23:16], sgr[23:16], sb[23:16]};
        end
    end

    assign out_valid = vld14_reg;
    assign out_argb  = argb14_reg;

endmodule
